// ===== rtl/dllf_pkg.sv =====
// Package for the diode-ladder lowpass filter: sequencer states, register
// codes and fixed-point constants. No dependencies.
package dllf_pkg;

   localparam int OVERSAMPLE_DEF   = 4;
   localparam int SAMPLE_WIDTH_DEF = 24;

   localparam logic [15:0] LAG_COEFF_RST  = 16'd2674;
   localparam logic [23:0] FREQ_SCALE_RST = 24'd140551;
   localparam logic [30:0] CUTOFF_RST     = 31'(800 << 16);

   localparam logic [14:0] CUT_MIN = 15'd20;
   localparam logic [14:0] CUT_MAX = 15'd18000;
   localparam logic [15:0] RES_MAX = 16'd4096;

   localparam logic signed [35:0] C_090     = 36'sd58982;
   localparam logic signed [35:0] C_110     = 36'sd72090;
   localparam logic signed [35:0] C_095     = 36'sd62259;
   localparam logic signed [35:0] C_040     = 36'sd26214;
   localparam logic signed [35:0] C_120     = 36'sd78643;
   localparam logic signed [35:0] C_390     = 36'sd255590;
   localparam logic [16:0]        C_060     = 17'd39322;
   localparam logic [34:0]        C_002_Q24 = 35'd335544;
   localparam logic [34:0]        Q28_27    = 35'd7247757312;
   localparam logic [33:0]        Q28_3     = 34'd805306368;
   localparam logic [28:0]        Q28_ONE   = 29'd268435456;

   localparam logic [4:0] DIV_STEPS_G = 5'd16;
   localparam logic [4:0] DIV_STEPS_S = 5'd29;

   localparam logic REG_LAG_COEFF  = 1'b0;
   localparam logic REG_FREQ_SCALE = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LAG_MUL,
      ST_LAG_ACC,
      ST_F_MUL,
      ST_F_WB,
      ST_G1,
      ST_G2,
      ST_G3,
      ST_GW,
      ST_DIVG,
      ST_KS_MUL,
      ST_KR_MUL,
      ST_K_MUL,
      ST_IN_MUL,
      ST_IN_WB,
      ST_FB_MUL,
      ST_FB_WB,
      ST_SAT_SQ,
      ST_SAT_NUM,
      ST_SAT_DINIT,
      ST_SAT_DIV,
      ST_SAT_FIN,
      ST_UPD_MUL,
      ST_UPD_WB,
      ST_OUT
   } state_type;

endpackage

// ===== rtl/diode_ladder_lowpass_filter_top.sv =====
// The shared 36x36 multiplier and the one-bit-per-cycle dividers set the pace: 16 steps for
// the gain normalization, 29 in each saturator call below |x| = 3. A result also waits in
// ST_OUT while the output register still holds one that was not taken.
// Flow: a new sample is taken only in ST_IDLE, once the last one is through the sequencer;
// it is taken while the last result still waits in the output register.
// Reset (synchronous, active high): stages zero, smoothed cutoff 800 Hz,
// registers to their defaults.
// Diode-ladder lowpass filter top level; uses dllf_pkg.
module diode_ladder_lowpass_filter_top #(
   parameter int OVERSAMPLE   = dllf_pkg::OVERSAMPLE_DEF,
   parameter int SAMPLE_WIDTH = dllf_pkg::SAMPLE_WIDTH_DEF,
   localparam int REQ_W = ((SAMPLE_WIDTH + 31 + 7) / 8) * 8,
   localparam int RSP_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // sample_in, cutoff_hz[14:0], resonance[15:0]
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // sample_out
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int SW   = SAMPLE_WIDTH;
   localparam int SH   = 29 - SW;
   localparam int SHL  = (SH >= 0) ? SH : 0;
   localparam int SHR  = (SH < 0) ? -SH : 0;
   localparam logic signed [71:0] RND_IN  = 72'sd1 <<< SHR >>> 1;
   localparam logic signed [71:0] RND_OUT = 72'sd1 <<< SHL >>> 1;
   localparam logic signed [71:0] OUT_MAX = (72'sd1 <<< (SW - 1)) - 72'sd1;
   localparam logic signed [71:0] OUT_MIN = -(72'sd1 <<< (SW - 1));
   localparam int IW = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
   localparam logic [IW-1:0] ITER_LAST = IW'(OVERSAMPLE - 1);

   localparam logic signed [71:0] R15 = 72'sd32768;
   localparam logic signed [71:0] R23 = 72'sd8388608;
   localparam logic signed [71:0] R27 = 72'sd134217728;
   localparam logic signed [71:0] S32_MAX = 72'sd2147483647;
   localparam logic signed [71:0] S32_MIN = -72'sd2147483648;

   dllf_pkg::state_type state_ff, state_in;

   logic [15:0] lag_ff;
   logic [23:0] fs_ff;

   logic signed [SW-1:0] smp_ff;
   logic [14:0]          cut_ff;
   logic [15:0]          res_ff;
   logic [30:0]          sc_ff;
   logic [31:0]          f_ff;
   logic [31:0]          g_ff [4];
   logic [16:0]          kscale_ff;
   logic signed [31:0]   k_ff;
   logic signed [33:0]   in12_ff;
   logic signed [31:0]   stage_ff [4];
   logic signed [29:0]   satc_ff [4];
   logic signed [29:0]   xs_ff;
   logic signed [33:0]   x_ff;
   logic                 big_ff;
   logic                 sat_x_ff;
   logic [1:0]           j_ff;
   logic [IW-1:0]        i_ff;
   logic signed [71:0]   prod_ff;
   logic [34:0]          rem_ff;
   logic [34:0]          den_ff;
   logic [28:0]          quo_ff;
   logic [28:0]          numlo_ff;
   logic [4:0]           cnt_ff;
   logic                 rsp_valid_ff;
   logic [SW-1:0]        rsp_data_ff;

   logic signed [35:0] mul_a, mul_b;
   logic               req_acc, cfg_wr, div_last;
   logic [33:0]        ax;
   logic [35:0]        r2;
   logic               ge;
   logic [35:0]        r2_sub;
   logic signed [71:0] rnd16, rnd24, rnd28, s28, upd_n, out_v;
   logic signed [29:0] inj;
   logic signed [30:0] ddiff;
   logic [31:0]        x2;
   logic [28:0]        ymag;
   logic signed [29:0] yval;
   logic [14:0]        cut_c;
   logic [15:0]        res_c;
   logic signed [31:0] upd_sat;
   logic [SW-1:0]      out_sat;

   assign req_acc    = req_tvalid && req_tready;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == dllf_pkg::REG_FREQ_SCALE) ?
                       {8'd0, fs_ff} : {16'd0, lag_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   always_comb begin
      cut_c = req_tdata[SW+14:SW];
      if (cut_c < dllf_pkg::CUT_MIN) cut_c = dllf_pkg::CUT_MIN;
      if (cut_c > dllf_pkg::CUT_MAX) cut_c = dllf_pkg::CUT_MAX;
      res_c = req_tdata[SW+30:SW+15];
      if (res_c > dllf_pkg::RES_MAX) res_c = dllf_pkg::RES_MAX;
   end

   // datapath helpers
   always_comb begin
      rnd16  = (prod_ff + R15) >>> 16;
      rnd24  = (prod_ff + R23) >>> 24;
      rnd28  = (prod_ff + R27) >>> 28;
      s28    = ((72'(smp_ff) <<< SHL) + RND_IN) >>> SHR;
      ax     = x_ff[33] ? 34'(-x_ff) : 34'(x_ff);
      r2     = {rem_ff, numlo_ff[28]};
      ge     = r2 >= {1'b0, den_ff};
      r2_sub = r2 - {1'b0, den_ff};
      x2     = prod_ff[59:28];
      ymag   = big_ff ? dllf_pkg::Q28_ONE : quo_ff;
      yval   = x_ff[33] ? -$signed({1'b0, ymag}) : $signed({1'b0, ymag});
      inj    = (j_ff == 2'd0) ? xs_ff : satc_ff[j_ff - 2'd1];
      ddiff  = 31'(inj) - 31'(satc_ff[j_ff]);
      upd_n  = 72'(stage_ff[j_ff]) + rnd24;
      if (upd_n > S32_MAX)      upd_sat = 32'(S32_MAX);
      else if (upd_n < S32_MIN) upd_sat = 32'(S32_MIN);
      else                      upd_sat = upd_n[31:0];
      out_v  = ((72'(stage_ff[3]) <<< SHR) + RND_OUT) >>> SHL;
      if (out_v > OUT_MAX)      out_sat = OUT_MAX[SW-1:0];
      else if (out_v < OUT_MIN) out_sat = OUT_MIN[SW-1:0];
      else                      out_sat = out_v[SW-1:0];
      div_last = cnt_ff == 5'd1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dllf_pkg::ST_IDLE:      if (req_acc) state_in = dllf_pkg::ST_LAG_MUL;
         dllf_pkg::ST_LAG_MUL:   state_in = dllf_pkg::ST_LAG_ACC;
         dllf_pkg::ST_LAG_ACC:   state_in = dllf_pkg::ST_F_MUL;
         dllf_pkg::ST_F_MUL:     state_in = dllf_pkg::ST_F_WB;
         dllf_pkg::ST_F_WB:      state_in = dllf_pkg::ST_G1;
         dllf_pkg::ST_G1:        state_in = dllf_pkg::ST_G2;
         dllf_pkg::ST_G2:        state_in = dllf_pkg::ST_G3;
         dllf_pkg::ST_G3:        state_in = dllf_pkg::ST_GW;
         dllf_pkg::ST_GW:        state_in = dllf_pkg::ST_DIVG;
         dllf_pkg::ST_DIVG:      if (div_last) state_in = dllf_pkg::ST_KS_MUL;
         dllf_pkg::ST_KS_MUL:    state_in = dllf_pkg::ST_KR_MUL;
         dllf_pkg::ST_KR_MUL:    state_in = dllf_pkg::ST_K_MUL;
         dllf_pkg::ST_K_MUL:     state_in = dllf_pkg::ST_IN_MUL;
         dllf_pkg::ST_IN_MUL:    state_in = dllf_pkg::ST_IN_WB;
         dllf_pkg::ST_IN_WB:     state_in = dllf_pkg::ST_FB_MUL;
         dllf_pkg::ST_FB_MUL:    state_in = dllf_pkg::ST_FB_WB;
         dllf_pkg::ST_FB_WB:     state_in = dllf_pkg::ST_SAT_SQ;
         dllf_pkg::ST_SAT_SQ:    state_in = (ax >= dllf_pkg::Q28_3) ?
                                            dllf_pkg::ST_SAT_FIN : dllf_pkg::ST_SAT_NUM;
         dllf_pkg::ST_SAT_NUM:   state_in = dllf_pkg::ST_SAT_DINIT;
         dllf_pkg::ST_SAT_DINIT: state_in = dllf_pkg::ST_SAT_DIV;
         dllf_pkg::ST_SAT_DIV:   if (div_last) state_in = dllf_pkg::ST_SAT_FIN;
         dllf_pkg::ST_SAT_FIN: begin
            if (sat_x_ff || j_ff != 2'd3) state_in = dllf_pkg::ST_UPD_MUL;
            else if (i_ff == ITER_LAST)   state_in = dllf_pkg::ST_OUT;
            else                          state_in = dllf_pkg::ST_FB_MUL;
         end
         dllf_pkg::ST_UPD_MUL:   state_in = dllf_pkg::ST_UPD_WB;
         dllf_pkg::ST_UPD_WB:    state_in = dllf_pkg::ST_SAT_SQ;
         dllf_pkg::ST_OUT:       if (!rsp_valid_ff || rsp_tready) state_in = dllf_pkg::ST_IDLE;
         default:                state_in = dllf_pkg::ST_IDLE;
      endcase
   end

   // multiplier operands and handshake outputs
   always_comb begin
      req_tready = state_ff == dllf_pkg::ST_IDLE;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         dllf_pkg::ST_LAG_MUL: begin
            mul_a = $signed({5'd0, cut_ff, 16'd0}) - $signed({5'd0, sc_ff});
            mul_b = $signed({20'd0, lag_ff});
         end
         dllf_pkg::ST_F_MUL: begin
            mul_a = $signed({5'd0, sc_ff});
            mul_b = $signed({12'd0, fs_ff});
         end
         dllf_pkg::ST_G1: begin
            mul_a = $signed({4'd0, f_ff});
            mul_b = dllf_pkg::C_090;
         end
         dllf_pkg::ST_G2: begin
            mul_a = $signed({4'd0, f_ff});
            mul_b = dllf_pkg::C_110;
         end
         dllf_pkg::ST_G3: begin
            mul_a = $signed({4'd0, f_ff});
            mul_b = dllf_pkg::C_095;
         end
         dllf_pkg::ST_KS_MUL: begin
            mul_a = $signed({20'd0, quo_ff[15:0]});
            mul_b = dllf_pkg::C_040;
         end
         dllf_pkg::ST_KR_MUL: begin
            mul_a = $signed({20'd0, res_ff});
            mul_b = dllf_pkg::C_390;
         end
         dllf_pkg::ST_K_MUL: begin
            mul_a = prod_ff[35:0];
            mul_b = $signed({19'd0, kscale_ff});
         end
         dllf_pkg::ST_IN_MUL: begin
            mul_a = s28[35:0];
            mul_b = dllf_pkg::C_120;
         end
         dllf_pkg::ST_FB_MUL: begin
            mul_a = 36'(k_ff);
            mul_b = 36'(satc_ff[3]);
         end
         dllf_pkg::ST_SAT_SQ: begin
            mul_a = $signed({2'd0, ax});
            mul_b = $signed({2'd0, ax});
         end
         dllf_pkg::ST_SAT_NUM: begin
            mul_a = $signed({2'd0, ax});
            mul_b = $signed({1'b0, dllf_pkg::Q28_27 + {3'd0, x2}});
         end
         dllf_pkg::ST_UPD_MUL: begin
            mul_a = $signed({4'd0, g_ff[j_ff]});
            mul_b = 36'(ddiff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dllf_pkg::ST_IDLE;
         lag_ff       <= dllf_pkg::LAG_COEFF_RST;
         fs_ff        <= dllf_pkg::FREQ_SCALE_RST;
         sc_ff        <= dllf_pkg::CUTOFF_RST;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < 4; n++) begin
            stage_ff[n] <= '0;
            satc_ff[n]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (cfg_wr) begin
            if (csr_paddr[2] == dllf_pkg::REG_LAG_COEFF) lag_ff <= csr_pwdata[15:0];
            else                                        fs_ff  <= csr_pwdata[23:0];
         end
         if (state_ff == dllf_pkg::ST_OUT && (!rsp_valid_ff || rsp_tready))
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            dllf_pkg::ST_LAG_ACC: sc_ff <= 31'($signed({41'd0, sc_ff}) + rnd16);
            dllf_pkg::ST_UPD_WB:  stage_ff[j_ff] <= upd_sat;
            dllf_pkg::ST_SAT_FIN: if (!sat_x_ff) satc_ff[j_ff] <= yval;
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         dllf_pkg::ST_IDLE: begin
            smp_ff <= req_tdata[SW-1:0];
            cut_ff <= cut_c;
            res_ff <= res_c;
         end
         dllf_pkg::ST_F_WB: begin
            f_ff    <= rnd24[31:0];
            g_ff[0] <= rnd24[31:0];
         end
         dllf_pkg::ST_G2: g_ff[1] <= rnd16[31:0];
         dllf_pkg::ST_G3: g_ff[2] <= rnd16[31:0];
         dllf_pkg::ST_GW: begin
            g_ff[3]  <= rnd16[31:0];
            rem_ff   <= {3'd0, f_ff};
            den_ff   <= {3'd0, f_ff} + dllf_pkg::C_002_Q24;
            numlo_ff <= '0;
            quo_ff   <= '0;
            cnt_ff   <= dllf_pkg::DIV_STEPS_G;
         end
         dllf_pkg::ST_DIVG, dllf_pkg::ST_SAT_DIV: begin
            rem_ff   <= ge ? r2_sub[34:0] : r2[34:0];
            quo_ff   <= {quo_ff[27:0], ge};
            numlo_ff <= {numlo_ff[27:0], 1'b0};
            cnt_ff   <= cnt_ff - 5'd1;
         end
         dllf_pkg::ST_KR_MUL: kscale_ff <= dllf_pkg::C_060 + rnd16[16:0];
         dllf_pkg::ST_IN_MUL: k_ff <= rnd16[31:0];
         dllf_pkg::ST_IN_WB: begin
            in12_ff <= rnd16[33:0];
            i_ff    <= '0;
         end
         dllf_pkg::ST_FB_MUL: j_ff <= 2'd0;
         dllf_pkg::ST_FB_WB: begin
            x_ff     <= 34'(72'(in12_ff) - rnd28);
            sat_x_ff <= 1'b1;
         end
         dllf_pkg::ST_SAT_SQ: big_ff <= ax >= dllf_pkg::Q28_3;
         dllf_pkg::ST_SAT_NUM: den_ff <= dllf_pkg::Q28_27 + 35'({3'd0, x2} * 35'd9);
         dllf_pkg::ST_SAT_DINIT: begin
            rem_ff   <= prod_ff[63:29];
            numlo_ff <= prod_ff[28:0];
            quo_ff   <= '0;
            cnt_ff   <= dllf_pkg::DIV_STEPS_S;
         end
         dllf_pkg::ST_SAT_FIN: begin
            if (sat_x_ff) begin
               xs_ff    <= yval;
               sat_x_ff <= 1'b0;
            end else if (j_ff != 2'd3) begin
               j_ff <= j_ff + 2'd1;
            end else begin
               i_ff <= i_ff + IW'(1);
            end
         end
         dllf_pkg::ST_UPD_WB: x_ff <= 34'(upd_sat);
         dllf_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) rsp_data_ff <= out_sat;
         end
         default: ;
      endcase
   end

   smoothed_cutoff_in_range: assert property (@(posedge clock) disable iff (reset)
      sc_ff >= 31'(20 << 16) && sc_ff <= 31'(18000 << 16))
      else $error("smoothed cutoff left its clamp range");

   div_remainder_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dllf_pkg::ST_DIVG || state_ff == dllf_pkg::ST_SAT_DIV) |->
      rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("new transaction taken while busy");

   gnorm_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff == dllf_pkg::ST_KS_MUL |-> quo_ff[28:16] == '0)
      else $error("gain normalization quotient overflow");

endmodule
